[sv/tsf_pkg.sv]
// Package for the touch sample filter: item structs, controller/datapath
// command and status structs, register indexes and fixed constants.
// No dependencies.
`default_nettype none

package tsf_pkg;

    // Sample item from the converter interface
    typedef struct packed {
        logic        pen_released;
        logic [11:0] sample_first_channel;
        logic [11:0] sample_second_channel;
    } in_item_t;

    // Pen event item
    typedef struct packed {
        logic [1:0]  event_kind;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic        for_calibration;
    } out_item_t;

    // Event kinds
    localparam logic [1:0] EV_DOWN = 2'd0;
    localparam logic [1:0] EV_MOVE = 2'd1;
    localparam logic [1:0] EV_UP   = 2'd2;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_CALIBRATING   = 3'd0,
        CFG_CAL_X_LOW     = 3'd1,
        CFG_CAL_X_HIGH    = 3'd2,
        CFG_CAL_Y_LOW     = 3'd3,
        CFG_CAL_Y_HIGH    = 3'd4,
        CFG_SCREEN_WIDTH  = 3'd5,
        CFG_SCREEN_HEIGHT = 3'd6,
        CFG_DEAD_ZONE     = 3'd7
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    // Burst and divider constants
    localparam logic [3:0] BURST_LAST = 4'd9;    // index of the tenth sample
    localparam int         DIV_STEPS  = 24;      // quotient bits per division
    localparam int         DIV_CNT_W  = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Controller to datapath
    typedef struct packed {
        logic accept_sample;
        logic accept_up;
        logic do_avg;
        logic do_mul;
        logic div_step;
        logic do_check;
        logic commit;
        logic emit_up;
    } tsf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_sample;
        logic suppress;
        logic calibrating;
        logic slot_free;
    } tsf_status_t;

endpackage

`default_nettype wire

[sv/tsf_ctrl.sv]
// Controller for the touch sample filter: one-hot sequencer over
// accumulate, average, multiply, divide, check, decide and pen-up steps.
// Depends on tsf_pkg.
`default_nettype none

module tsf_ctrl
    import tsf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        sample_valid,
    input  wire logic        pen_released,
    input  wire tsf_status_t status,
    output tsf_cmd_t         cmd,
    output logic             idle
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_AVG    = 7'b0000010,
        S_MUL    = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_CHECK  = 7'b0010000,
        S_DECIDE = 7'b0100000,
        S_UP     = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    // State register and divider step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        idle       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                if (sample_valid)
                begin
                    if (pen_released)
                    begin
                        cmd.accept_up = 1'b1;
                        state_next    = S_UP;
                    end
                    else
                    begin
                        cmd.accept_sample = 1'b1;
                        if (status.last_sample)
                            state_next = S_AVG;
                    end
                end
            end
            S_AVG:
            begin
                cmd.do_avg = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.do_mul = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.do_check = 1'b1;
                state_next   = S_DECIDE;
            end
            S_DECIDE:
            begin
                // suppressed move, silent calibration update, event, or wait
                priority if (status.suppress)
                    state_next = S_IDLE;
                else if (status.calibrating || status.slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_DECIDE;
            end
            S_UP:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_up = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/tsf_datapath.sv]
// Datapath for the touch sample filter: configuration registers, burst
// accumulators, trimmed mean, two-lane scaling divider and event register.
// Depends on tsf_pkg.
`default_nettype none

module tsf_datapath
    import tsf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tsf_cmd_t               cmd,
    output tsf_status_t                 status,
    input  wire in_item_t               sample_item,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                        event_valid,
    input  wire logic                   event_stall,
    output out_item_t                   event_item
);

    // Configuration
    logic        calibrating_reg;
    logic [11:0] cal_x_low_reg, cal_x_high_reg, cal_y_low_reg, cal_y_high_reg;
    logic [11:0] screen_width_reg, screen_height_reg;
    logic [7:0]  dead_zone_reg;

    // Burst state
    logic [3:0]  burst_count_reg;
    logic [15:0] sum_x_reg, sum_y_reg;
    logic [11:0] least_x_reg, greatest_x_reg, least_y_reg, greatest_y_reg;

    // Position state
    logic [11:0] current_x_reg, current_y_reg, reported_x_reg, reported_y_reg;
    logic        pen_down_reg;

    // Scaling lanes
    logic [11:0] avg_x_reg, avg_y_reg;
    logic [11:0] span_x_reg, span_y_reg;
    logic [11:0] rem_x_reg, rem_y_reg;
    logic [23:0] quo_x_reg, quo_y_reg;
    logic        zero_x_reg, zero_y_reg;

    // Output register
    logic        event_valid_reg;
    out_item_t   event_item_reg;

    logic [11:0] sx, sy;
    logic [15:0] trim_x, trim_y;
    logic [11:0] num_x, num_y;
    logic [11:0] dx, dy;
    logic        slot_free;

    // Numerator on the screen side of the low limit
    function automatic logic [11:0] span_num(input logic [11:0] avg,
                                             input logic [11:0] low,
                                             input logic [11:0] high);
        span_num = (high > low) ? (avg - low) : (low - avg);
    endfunction

    // Coordinate forced to zero
    function automatic logic force_zero(input logic [11:0] avg,
                                        input logic [11:0] low,
                                        input logic [11:0] high,
                                        input logic [11:0] size);
        logic far;
        far = (high > low) ? (avg <= low) : (avg >= low);
        force_zero = (size == '0) || (low == high) || far;
    endfunction

    // One restoring division step: {remainder, quotient}
    function automatic logic [35:0] div_once(input logic [11:0] rem,
                                             input logic [23:0] quo,
                                             input logic [11:0] span);
        logic [12:0] trial;
        trial = {rem, quo[23]};
        if (trial >= {1'b0, span})
            div_once = {12'(trial - {1'b0, span}), quo[22:0], 1'b1};
        else
            div_once = {trial[11:0], quo[22:0], 1'b0};
    endfunction

    // Clamp quotient to the screen
    function automatic logic [11:0] clamp_q(input logic [23:0] quo,
                                            input logic [11:0] size,
                                            input logic        zero);
        logic [11:0] top;
        top = size - 12'd1;
        if (zero)
            clamp_q = '0;
        else if (quo > {12'b0, top})
            clamp_q = top;
        else
            clamp_q = quo[11:0];
    endfunction

    function automatic logic [11:0] abs_diff(input logic [11:0] a,
                                             input logic [11:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    assign sx     = sample_item.sample_second_channel;
    assign sy     = sample_item.sample_first_channel;
    assign trim_x = sum_x_reg - {4'b0, least_x_reg} - {4'b0, greatest_x_reg};
    assign trim_y = sum_y_reg - {4'b0, least_y_reg} - {4'b0, greatest_y_reg};
    assign num_x  = span_num(avg_x_reg, cal_x_low_reg, cal_x_high_reg);
    assign num_y  = span_num(avg_y_reg, cal_y_low_reg, cal_y_high_reg);
    assign dx     = abs_diff(reported_x_reg, current_x_reg);
    assign dy     = abs_diff(reported_y_reg, current_y_reg);
    assign slot_free = !event_valid_reg || !event_stall;

    // Status to the controller
    always_comb
    begin
        status.last_sample = (burst_count_reg == BURST_LAST);
        status.suppress    = pen_down_reg && (dx < {4'b0, dead_zone_reg})
                             && (dy < {4'b0, dead_zone_reg});
        status.calibrating = calibrating_reg;
        status.slot_free   = slot_free;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calibrating_reg   <= 1'b0;
            cal_x_low_reg     <= 12'd0;
            cal_x_high_reg    <= 12'd4095;
            cal_y_low_reg     <= 12'd0;
            cal_y_high_reg    <= 12'd4095;
            screen_width_reg  <= 12'd240;
            screen_height_reg <= 12'd320;
            dead_zone_reg     <= 8'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CALIBRATING:   calibrating_reg   <= cfg_data[0];
                CFG_CAL_X_LOW:     cal_x_low_reg     <= cfg_data;
                CFG_CAL_X_HIGH:    cal_x_high_reg    <= cfg_data;
                CFG_CAL_Y_LOW:     cal_y_low_reg     <= cfg_data;
                CFG_CAL_Y_HIGH:    cal_y_high_reg    <= cfg_data;
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                CFG_DEAD_ZONE:     dead_zone_reg     <= cfg_data[7:0];
                default:           calibrating_reg   <= calibrating_reg;
            endcase
        end
    end

    // Burst accumulation, trimmed mean, position tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_count_reg <= '0;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            least_x_reg     <= 12'd4095;
            greatest_x_reg  <= '0;
            least_y_reg     <= 12'd4095;
            greatest_y_reg  <= '0;
            current_x_reg   <= '0;
            current_y_reg   <= '0;
            reported_x_reg  <= '0;
            reported_y_reg  <= '0;
            pen_down_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.accept_sample)
            begin
                burst_count_reg <= burst_count_reg + 4'd1;
                sum_x_reg       <= sum_x_reg + {4'b0, sx};
                sum_y_reg       <= sum_y_reg + {4'b0, sy};
                if (sx < least_x_reg)    least_x_reg    <= sx;
                if (sx > greatest_x_reg) greatest_x_reg <= sx;
                if (sy < least_y_reg)    least_y_reg    <= sy;
                if (sy > greatest_y_reg) greatest_y_reg <= sy;
            end
            // burst end or pen up drops the partial burst
            if (cmd.do_avg || cmd.accept_up)
            begin
                burst_count_reg <= '0;
                sum_x_reg       <= '0;
                sum_y_reg       <= '0;
                least_x_reg     <= 12'd4095;
                greatest_x_reg  <= '0;
                least_y_reg     <= 12'd4095;
                greatest_y_reg  <= '0;
            end
            if (cmd.accept_up)
                pen_down_reg <= 1'b0;
            if (cmd.do_check)
            begin
                if (calibrating_reg)
                begin
                    current_x_reg <= avg_x_reg;
                    current_y_reg <= avg_y_reg;
                end
                else
                begin
                    current_x_reg <= clamp_q(quo_x_reg, screen_width_reg, zero_x_reg);
                    current_y_reg <= clamp_q(quo_y_reg, screen_height_reg, zero_y_reg);
                end
            end
            if (cmd.commit)
            begin
                pen_down_reg   <= 1'b1;
                reported_x_reg <= current_x_reg;
                reported_y_reg <= current_y_reg;
            end
        end
    end

    // Scaling lanes: average, product, then one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.do_avg)
        begin
            avg_x_reg <= trim_x[14:3];
            avg_y_reg <= trim_y[14:3];
        end
        if (cmd.do_mul)
        begin
            quo_x_reg  <= {12'b0, num_x} * {12'b0, screen_width_reg};
            quo_y_reg  <= {12'b0, num_y} * {12'b0, screen_height_reg};
            rem_x_reg  <= '0;
            rem_y_reg  <= '0;
            span_x_reg <= (cal_x_high_reg > cal_x_low_reg) ?
                          (cal_x_high_reg - cal_x_low_reg) : (cal_x_low_reg - cal_x_high_reg);
            span_y_reg <= (cal_y_high_reg > cal_y_low_reg) ?
                          (cal_y_high_reg - cal_y_low_reg) : (cal_y_low_reg - cal_y_high_reg);
            zero_x_reg <= force_zero(avg_x_reg, cal_x_low_reg, cal_x_high_reg,
                                     screen_width_reg);
            zero_y_reg <= force_zero(avg_y_reg, cal_y_low_reg, cal_y_high_reg,
                                     screen_height_reg);
        end
        if (cmd.div_step)
        begin
            {rem_x_reg, quo_x_reg} <= div_once(rem_x_reg, quo_x_reg, span_x_reg);
            {rem_y_reg, quo_y_reg} <= div_once(rem_y_reg, quo_y_reg, span_y_reg);
        end
    end

    // Event output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            event_valid_reg <= 1'b0;
        else if (cmd.emit_up || (cmd.commit && !calibrating_reg))
            event_valid_reg <= 1'b1;
        else if (!event_stall)
            event_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_up)
        begin
            event_item_reg.event_kind      <= EV_UP;
            event_item_reg.pos_x           <= current_x_reg;
            event_item_reg.pos_y           <= current_y_reg;
            event_item_reg.for_calibration <= calibrating_reg;
        end
        else if (cmd.commit && !calibrating_reg)
        begin
            event_item_reg.event_kind      <= pen_down_reg ? EV_MOVE : EV_DOWN;
            event_item_reg.pos_x           <= current_x_reg;
            event_item_reg.pos_y           <= current_y_reg;
            event_item_reg.for_calibration <= 1'b0;
        end
    end

    assign event_valid = event_valid_reg;
    assign event_item  = event_item_reg;

endmodule

`default_nettype wire

[sv/touch_sample_filter_and_pen_events_core.sv]
// Touch sample filter and pen event generator, top level.
// Instantiates tsf_ctrl and tsf_datapath; depends on tsf_pkg.
//
// Usage:
//   Sample channel (sample_valid / sample_stall / sample_item): one sample
//   pair or a pen-up marker per item. Event channel (event_valid /
//   event_stall / event_item): pen down, move and up events. Both channels
//   move an item at a clock edge with valid high and stall low.
//   Configuration: cfg_we with cfg_index/cfg_data writes one register per
//   cycle; write only while the block is idle.
// Sequence:
//   Samples one to nine of a burst are only accumulated. The tenth runs
//   trimmed mean, product, 24 restoring division steps (one quotient
//   bit per cycle, both axes in parallel), clamp and dead-zone decision;
//   unless suppressed or calibrating, an event then waits for a free
//   output register. A pen-up item's event also waits for a free slot.
// Reset and stall:
//   rst_n clears configuration to defaults and empties burst and position
//   state. The output register holds one event; a new item is accepted while
//   it waits, and the sequencer only waits when a second event is ready
//   before the first has been taken.
`default_nettype none

module touch_sample_filter_and_pen_events_core
    import tsf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   sample_valid,
    output logic                        sample_stall,
    input  wire in_item_t               sample_item,
    output logic                        event_valid,
    input  wire logic                   event_stall,
    output out_item_t                   event_item,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    tsf_cmd_t    cmd;
    tsf_status_t status;
    logic        idle;

    tsf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .pen_released (sample_item.pen_released),
        .status       (status),
        .cmd          (cmd),
        .idle         (idle)
    );

    tsf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .sample_item (sample_item),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_item  (event_item)
    );

    assign sample_stall = !idle;

    // Sequencer issues at most one command per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept_sample, cmd.accept_up, cmd.do_avg, cmd.do_mul,
                  cmd.div_step, cmd.do_check, cmd.commit, cmd.emit_up}))
        else $error("more than one datapath command in a cycle");

    // An event is loaded only into a free output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_up || (cmd.commit && !status.calibrating)) |-> status.slot_free)
        else $error("event loaded over an untaken event");

    // The tenth sample of a burst starts the scaling sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept_sample && status.last_sample) |=> (sample_stall && cmd.do_avg))
        else $error("burst end did not start averaging");

    // A pen-up item leads to its event in the next cycle when the slot is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept_up ##1 status.slot_free) |-> cmd.emit_up)
        else $error("pen-up event not issued");

endmodule

`default_nettype wire
